// ----- design/srsm_pkg.sv -----
// ----------------------------------------------------------------------------
// srsm_pkg
// Shared types, constants and elaboration helpers for the square-root block.
// ----------------------------------------------------------------------------
package srsm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 16;
  localparam int DSR_W         = 7;

  typedef enum logic [2:0] {
    MODE_HALF   = 3'd0,
    MODE_COARSE = 3'd1,
    MODE_TABLE  = 3'd2,
    MODE_LINEAR = 3'd3,
    MODE_EXACT  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CLS_LOW  = 2'd0,
    CLS_MID  = 2'd1,
    CLS_HIGH = 2'd2
  } cls_e;

  typedef struct packed {
    logic  valid;
    mode_e mode;
  } tag_t;

  // seed values in hundredths
  localparam logic [9:0] SEED_HUND [10] = '{
    10'd200, 10'd400, 10'd500, 10'd600, 10'd675,
    10'd740, 10'd810, 10'd870, 10'd925, 10'd975
  };

  function automatic int root_bits(input int frac);
    return (32 + frac + 1) / 2;
  endfunction

  function automatic logic [63:0] one_q(input int frac);
    return 64'd1 << frac;
  endfunction

  // upper bound of table bucket k (1 to 9) for a scale class
  function automatic logic [63:0] thr_q(input cls_e cls, input int k, input int frac);
    logic [63:0] q;
    q = one_q(frac);
    case (cls)
      CLS_LOW: return (64'(k) * q) / 64'd10;
      CLS_MID: return 64'(10 * k) * q;
      default: return 64'(1000 * k) * q;
    endcase
  endfunction

  function automatic logic [63:0] tab_q(input cls_e cls, input int idx, input int frac);
    logic [63:0] prod;
    prod = 64'(SEED_HUND[idx]) * one_q(frac);
    case (cls)
      CLS_LOW: return prod / 64'd1000;
      CLS_MID: return prod / 64'd100;
      default: return prod / 64'd10;
    endcase
  endfunction

  function automatic logic [63:0] lin_low(input int frac);
    return (64'd12 * one_q(frac)) / 64'd100;
  endfunction

  function automatic logic [63:0] out_lim(input int int_b, input int frac);
    if (int_b + frac >= 32) begin
      return 64'h0000_0000_FFFF_FFFF;
    end
    return (64'd1 << (int_b + frac)) - 64'd1;
  endfunction

endpackage

// ----- design/srsm_front.sv -----
// ----------------------------------------------------------------------------
// srsm_front
// Two entry stages: scale class, then seed estimates and chain operands.
// ----------------------------------------------------------------------------
module srsm_front import srsm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int INT_BITS  = INT_BITS_DEF,
  localparam int ROOT_BITS = root_bits(FRAC_BITS),
  localparam int RW        = 2 * ROOT_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       mode_i,
  input  logic [31:0]      value_i,
  input  logic             ready_i,
  output tag_t             tag_o,
  output logic [RW-1:0]    rad_o,
  output logic [RW-1:0]    dvd_o,
  output logic [DSR_W-1:0] dsr_o,
  output logic [31:0]      side_o
);

  localparam logic [31:0] VMASK = 32'(out_lim(INT_BITS, FRAC_BITS));
  localparam logic [63:0] ONE_Q = one_q(FRAC_BITS);

  logic        a_valid_q;
  mode_e       a_mode_q;
  cls_e        a_cls_q;
  logic [31:0] a_v_q;
  logic        a_ready;
  cls_e        a_cls_d;
  logic [31:0] a_v_d;

  logic             b_valid_q;
  mode_e            b_mode_q;
  logic             b_ready;
  logic [RW-1:0]    rad_q, rad_d;
  logic [RW-1:0]    dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [31:0]      side_q, side_d;

  logic [63:0] thr_c [3][9];
  logic [31:0] tab_c [3][10];
  logic [63:0] thr_row [9];
  logic [31:0] tab_row [10];
  logic [8:0]  le;
  logic [3:0]  idx;
  logic [63:0] v64;
  logic [31:0] coarse;

  for (genvar gc = 0; gc < 3; gc++) begin : g_cls
    for (genvar gk = 0; gk < 9; gk++) begin : g_thr
      localparam logic [63:0] T = thr_q(cls_e'(gc), gk + 1, FRAC_BITS);
      assign thr_c[gc][gk] = T;
    end
    for (genvar gt = 0; gt < 10; gt++) begin : g_tab
      localparam logic [63:0] S = tab_q(cls_e'(gc), gt, FRAC_BITS);
      assign tab_c[gc][gt] = S[31:0];
    end
  end

  // stage a: mask and classify
  always_comb begin
    a_v_d = value_i & VMASK;
    if ({32'd0, a_v_d} < ONE_Q) begin
      a_cls_d = CLS_LOW;
    end else if ({32'd0, a_v_d} > 64'd100 * ONE_Q) begin
      a_cls_d = CLS_HIGH;
    end else begin
      a_cls_d = CLS_MID;
    end
  end

  assign a_ready    = ~a_valid_q | b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_mode_q <= mode_e'(mode_i);
      a_cls_q  <= a_cls_d;
      a_v_q    <= a_v_d;
    end
  end

  // stage b: seeds and chain operands
  always_comb begin
    v64 = {32'd0, a_v_q};
    unique case (a_cls_q)
      CLS_LOW: begin
        thr_row = thr_c[0];
        tab_row = tab_c[0];
        coarse  = 32'(ONE_Q >> 1);
        dvd_d   = RW'(v64 + lin_low(FRAC_BITS));
        dsr_d   = DSR_W'(1);
      end
      CLS_MID: begin
        thr_row = thr_c[1];
        tab_row = tab_c[1];
        coarse  = 32'(64'd5 * ONE_Q);
        dvd_d   = RW'(v64 + 64'd12 * ONE_Q);
        dsr_d   = DSR_W'(10);
      end
      default: begin
        thr_row = thr_c[2];
        tab_row = tab_c[2];
        coarse  = 32'(64'd50 * ONE_Q);
        dvd_d   = RW'(v64 + 64'd1200 * ONE_Q);
        dsr_d   = DSR_W'(100);
      end
    endcase
    for (int k = 0; k < 9; k++) begin
      le[k] = (v64 <= thr_row[k]);
    end
    idx = 4'd9;
    for (int k = 8; k >= 0; k--) begin
      if (le[k]) begin
        idx = 4'(k);
      end
    end
    rad_d = RW'(v64 << FRAC_BITS);
    unique case (a_mode_q)
      MODE_HALF:   side_d = a_v_q >> 1;
      MODE_COARSE: side_d = coarse;
      MODE_TABLE:  side_d = tab_row[idx];
      default:     side_d = 32'd0;
    endcase
  end

  assign b_ready = ~b_valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_mode_q <= a_mode_q;
      rad_q    <= rad_d;
      dvd_q    <= dvd_d;
      dsr_q    <= dsr_d;
      side_q   <= side_d;
    end
  end

  assign tag_o  = '{valid: b_valid_q, mode: b_mode_q};
  assign rad_o  = rad_q;
  assign dvd_o  = dvd_q;
  assign dsr_o  = dsr_q;
  assign side_o = side_q;

endmodule

// ----- design/srsm_cell.sv -----
// ----------------------------------------------------------------------------
// srsm_cell
// One chain cell: one root bit by trial subtraction and one radix-4
// quotient digit of the seed division, registered.
// ----------------------------------------------------------------------------
module srsm_cell import srsm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int ROOT_BITS = root_bits(FRAC_BITS),
  localparam int RW        = 2 * ROOT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tag_t                 tag_i,
  output logic                 ready_o,
  input  logic [RW-1:0]        rad_i,
  input  logic [ROOT_BITS+1:0] srem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  input  logic [RW-1:0]        dvd_i,
  input  logic [DSR_W-1:0]     dsr_i,
  input  logic [DSR_W-1:0]     drem_i,
  input  logic [RW-1:0]        quot_i,
  input  logic [31:0]          side_i,
  output tag_t                 tag_o,
  input  logic                 ready_i,
  output logic [RW-1:0]        rad_o,
  output logic [ROOT_BITS+1:0] srem_o,
  output logic [ROOT_BITS-1:0] root_o,
  output logic [RW-1:0]        dvd_o,
  output logic [DSR_W-1:0]     dsr_o,
  output logic [DSR_W-1:0]     drem_o,
  output logic [RW-1:0]        quot_o,
  output logic [31:0]          side_o
);

  logic                 valid_q;
  mode_e                mode_q;
  logic [RW-1:0]        rad_q;
  logic [ROOT_BITS+1:0] srem_q, srem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic [RW-1:0]        dvd_q;
  logic [DSR_W-1:0]     dsr_q;
  logic [DSR_W-1:0]     drem_q, drem_d;
  logic [RW-1:0]        quot_q;
  logic [31:0]          side_q;
  logic [1:0]           qdig;

  logic [ROOT_BITS+3:0] cand;
  logic [ROOT_BITS+4:0] diff;
  logic                 ge;
  logic [DSR_W+1:0]     t, d1, d2, d3;

  // root bit
  always_comb begin
    cand   = {srem_i, rad_i[RW-1 -: 2]};
    diff   = {1'b0, cand} - {3'b000, root_i, 2'b01};
    ge     = ~diff[ROOT_BITS+4];
    srem_d = ge ? diff[ROOT_BITS+1:0] : cand[ROOT_BITS+1:0];
    root_d = {root_i[ROOT_BITS-2:0], ge};
  end

  // quotient digit
  always_comb begin
    t  = {drem_i, dvd_i[RW-1 -: 2]};
    d1 = {2'b00, dsr_i};
    d2 = {1'b0, dsr_i, 1'b0};
    d3 = d1 + d2;
    if (t >= d3) begin
      qdig   = 2'd3;
      drem_d = DSR_W'(t - d3);
    end else if (t >= d2) begin
      qdig   = 2'd2;
      drem_d = DSR_W'(t - d2);
    end else if (t >= d1) begin
      qdig   = 2'd1;
      drem_d = DSR_W'(t - d1);
    end else begin
      qdig   = 2'd0;
      drem_d = t[DSR_W-1:0];
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && tag_i.valid) begin
      mode_q <= tag_i.mode;
      rad_q  <= {rad_i[RW-3:0], 2'b00};
      srem_q <= srem_d;
      root_q <= root_d;
      dvd_q  <= {dvd_i[RW-3:0], 2'b00};
      dsr_q  <= dsr_i;
      drem_q <= drem_d;
      quot_q <= {quot_i[RW-3:0], qdig};
      side_q <= side_i;
    end
  end

  assign tag_o  = '{valid: valid_q, mode: mode_q};
  assign rad_o  = rad_q;
  assign srem_o = srem_q;
  assign root_o = root_q;
  assign dvd_o  = dvd_q;
  assign dsr_o  = dsr_q;
  assign drem_o = drem_q;
  assign quot_o = quot_q;
  assign side_o = side_q;

endmodule

// ----- design/srsm_back.sv -----
// ----------------------------------------------------------------------------
// srsm_back
// Result select by mode, saturation and the output register.
// ----------------------------------------------------------------------------
module srsm_back import srsm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int INT_BITS  = INT_BITS_DEF,
  localparam int ROOT_BITS = root_bits(FRAC_BITS),
  localparam int RW        = 2 * ROOT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tag_t                 tag_i,
  output logic                 ready_o,
  input  logic [ROOT_BITS-1:0] root_i,
  input  logic [RW-1:0]        quot_i,
  input  logic [31:0]          side_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          root_o
);

  localparam logic [63:0] LIM = out_lim(INT_BITS, FRAC_BITS);

  logic        out_valid_q;
  logic [31:0] res_q, res_d;
  logic [63:0] r;

  always_comb begin
    unique case (tag_i.mode)
      MODE_EXACT:  r = 64'(root_i);
      MODE_LINEAR: r = 64'(quot_i);
      default:     r = {32'd0, side_i};
    endcase
    res_d = (r > LIM) ? LIM[31:0] : r[31:0];
  end

  assign ready_o = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && tag_i.valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = res_q;

endmodule

// ----- design/square_root_with_seed_modes.sv -----
// ----------------------------------------------------------------------------
// square_root_with_seed_modes
// Fixed-point square root with seed estimate modes, built as a chain of
// bit cells between two entry stages and an output register.
// ----------------------------------------------------------------------------
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_ready_o    mode_i, value_i
// out      out  out_valid_o / out_ready_i  root_o
//
// one item per cycle sustained while out_ready_i is high; an item
// passes two entry stages, one cell per root bit and one output register,
// with ROOT_BITS = (33 + FRAC_BITS) / 2
// reset empties every stage; no clearing pass
// each stage holds only while its successor is full and stalled, so
// bubbles close up and input is taken while a result waits
// ----------------------------------------------------------------------------
module square_root_with_seed_modes import srsm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int INT_BITS  = INT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] root_o
);

  localparam int ROOT_BITS = root_bits(FRAC_BITS);
  localparam int RW        = 2 * ROOT_BITS;

  tag_t                 tag_w  [ROOT_BITS+1];
  logic                 rdy_w  [ROOT_BITS+1];
  logic [RW-1:0]        rad_w  [ROOT_BITS+1];
  logic [ROOT_BITS+1:0] srem_w [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root_w [ROOT_BITS+1];
  logic [RW-1:0]        dvd_w  [ROOT_BITS+1];
  logic [DSR_W-1:0]     dsr_w  [ROOT_BITS+1];
  logic [DSR_W-1:0]     drem_w [ROOT_BITS+1];
  logic [RW-1:0]        quot_w [ROOT_BITS+1];
  logic [31:0]          side_w [ROOT_BITS+1];

  srsm_front #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i    (mode_i),
    .value_i   (value_i),
    .ready_i   (rdy_w[0]),
    .tag_o     (tag_w[0]),
    .rad_o     (rad_w[0]),
    .dvd_o     (dvd_w[0]),
    .dsr_o     (dsr_w[0]),
    .side_o    (side_w[0])
  );

  assign srem_w[0] = '0;
  assign root_w[0] = '0;
  assign drem_w[0] = '0;
  assign quot_w[0] = '0;

  for (genvar gi = 0; gi < ROOT_BITS; gi++) begin : g_cell
    srsm_cell #(
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tag_i  (tag_w[gi]),
      .ready_o(rdy_w[gi]),
      .rad_i  (rad_w[gi]),
      .srem_i (srem_w[gi]),
      .root_i (root_w[gi]),
      .dvd_i  (dvd_w[gi]),
      .dsr_i  (dsr_w[gi]),
      .drem_i (drem_w[gi]),
      .quot_i (quot_w[gi]),
      .side_i (side_w[gi]),
      .tag_o  (tag_w[gi+1]),
      .ready_i(rdy_w[gi+1]),
      .rad_o  (rad_w[gi+1]),
      .srem_o (srem_w[gi+1]),
      .root_o (root_w[gi+1]),
      .dvd_o  (dvd_w[gi+1]),
      .dsr_o  (dsr_w[gi+1]),
      .drem_o (drem_w[gi+1]),
      .quot_o (quot_w[gi+1]),
      .side_o (side_w[gi+1])
    );
  end

  srsm_back #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (tag_w[ROOT_BITS]),
    .ready_o    (rdy_w[ROOT_BITS]),
    .root_i     (root_w[ROOT_BITS]),
    .quot_i     (quot_w[ROOT_BITS]),
    .side_i     (side_w[ROOT_BITS]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .root_o     (root_o)
  );

endmodule

// ----- design/srsm_checker.sv -----
// ----------------------------------------------------------------------------
// srsm_props
// Port-level checks on the square-root block, bound to the top level.
// ----------------------------------------------------------------------------
module srsm_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] root_o
);

  // a waiting result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(root_o))
    else $error("result changed while stalled");

  // empty output register means the whole chain can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with output empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked with output draining");

endmodule

bind square_root_with_seed_modes srsm_props u_srsm_props (.*);
